>>> hdl/mcts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mcts_pkg;

  // Fixed field widths of the request and result transactions
  localparam int TASK_IDX_W = 6;
  localparam int CNT_W      = 9;
  localparam int PRI_W      = 8;

  // Request kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_SCHED = 1'b1;

  // Which result the datapath builds when the controller asks for it
  typedef enum logic [1:0] {
    RES_WRITE,
    RES_IDLE,
    RES_SEL
  } res_kind_e;

  typedef struct packed {
    logic      wr_entry;    // load one table entry from the request
    logic      clear_cur;   // zero the current task's counter
    logic      pass_start;  // rewind the table pass and the running best
    logic      pass_run;    // issue the read of the next entry
    logic      rech_mode;   // the running pass recharges instead of scanning
    logic      out_load;    // move the result into the output register
    res_kind_e res_kind;
    logic      res_rech;
  } mcts_cmd_t;

  typedef struct packed {
    logic issue_last;  // the read of the last entry is being issued
    logic found;       // the scan saw at least one candidate
    logic best_zero;   // the best counter is zero
    logic out_free;    // the output register can take a result
  } mcts_status_t;

endpackage

`default_nettype wire

>>> hdl/mcts_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface mcts_in_if;
  logic                                valid;
  logic                                ready;
  logic                                kind;
  logic [mcts_pkg::TASK_IDX_W-1:0]     task_index;
  logic                                present;
  logic                                ready_req;
  logic [mcts_pkg::CNT_W-1:0]          slice_count;
  logic [mcts_pkg::PRI_W-1:0]          weight;

  modport source (
    output valid, kind, task_index, present, ready_req, slice_count, weight,
    input  ready
  );
  modport sink (
    input  valid, kind, task_index, present, ready_req, slice_count, weight,
    output ready
  );
endinterface

interface mcts_out_if;
  logic                                valid;
  logic                                ready;
  logic [mcts_pkg::TASK_IDX_W-1:0]     next_task;
  logic                                switched;
  logic                                idle;
  logic                                recharged;

  modport source (
    output valid, next_task, switched, idle, recharged,
    input  ready
  );
  modport sink (
    input  valid, next_task, switched, idle, recharged,
    output ready
  );
endinterface

`default_nettype wire

>>> hdl/mcts_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module mcts_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  input  wire logic                  in_kind_i,
  output logic                       in_ready_o,
  input  wire mcts_pkg::mcts_status_t status_i,
  output mcts_pkg::mcts_cmd_t        cmd_o
);
  import mcts_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_WAIT,
    S_DECIDE,
    S_RECH,
    S_RECH_WAIT,
    S_RESULT
  } state_e;

  state_e    state_q, state_d;
  res_kind_e res_kind_q, res_kind_d;
  logic      rech_q, rech_d;
  logic      in_accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o          = '0;
    cmd_o.res_kind = res_kind_q;
    cmd_o.res_rech = rech_q;
    state_d        = state_q;
    res_kind_d     = res_kind_q;
    rech_d         = rech_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          rech_d = 1'b0;
          if (in_kind_i == KIND_WRITE) begin
            cmd_o.wr_entry = 1'b1;
            res_kind_d     = RES_WRITE;
            state_d        = S_RESULT;
          end else begin
            cmd_o.clear_cur  = 1'b1;
            cmd_o.pass_start = 1'b1;
            state_d          = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd_o.pass_run = 1'b1;
        if (status_i.issue_last) begin
          state_d = S_SCAN_WAIT;
        end
      end
      S_SCAN_WAIT: begin
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        priority if (!status_i.found) begin
          res_kind_d = RES_IDLE;
          state_d    = S_RESULT;
        end else if (!status_i.best_zero) begin
          res_kind_d = RES_SEL;
          state_d    = S_RESULT;
        end else if (!rech_q) begin
          rech_d           = 1'b1;
          cmd_o.pass_start = 1'b1;
          state_d          = S_RECH;
        end else begin
          // recharge left every candidate at zero: report idle, no retry
          res_kind_d = RES_IDLE;
          state_d    = S_RESULT;
        end
      end
      S_RECH: begin
        cmd_o.pass_run  = 1'b1;
        cmd_o.rech_mode = 1'b1;
        if (status_i.issue_last) begin
          state_d = S_RECH_WAIT;
        end
      end
      S_RECH_WAIT: begin
        cmd_o.pass_start = 1'b1;
        state_d          = S_SCAN;
      end
      S_RESULT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      res_kind_q <= RES_WRITE;
      rech_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      res_kind_q <= res_kind_d;
      rech_q     <= rech_d;
    end
  end

  a_rech_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RECH |-> rech_q)
    else $error("recharge pass entered without the recharge mark");

  a_rech_from_decide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rech_q) |-> $past(state_q) == S_DECIDE)
    else $error("recharge mark set outside the decision step");

  a_accept_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> state_q == S_SCAN || state_q == S_RESULT)
    else $error("accepted transaction did not start work");

endmodule

`default_nettype wire

>>> hdl/mcts_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module mcts_datapath #(
  parameter int TASK_SLOTS = 64
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire mcts_pkg::mcts_cmd_t             cmd_i,
  output mcts_pkg::mcts_status_t               status_o,
  input  wire logic [mcts_pkg::TASK_IDX_W-1:0] task_index_i,
  input  wire logic                            present_i,
  input  wire logic                            ready_req_i,
  input  wire logic [mcts_pkg::CNT_W-1:0]      slice_count_i,
  input  wire logic [mcts_pkg::PRI_W-1:0]      weight_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [mcts_pkg::TASK_IDX_W-1:0]      next_task_o,
  output logic                                 switched_o,
  output logic                                 idle_o,
  output logic                                 recharged_o
);
  import mcts_pkg::*;

  localparam int IDX_W = $clog2(TASK_SLOTS);

  // Counter and priority stores; an entry whose valid bit is clear reads as its reset value
  logic [CNT_W-1:0] cnt_mem [TASK_SLOTS];
  logic [PRI_W-1:0] pri_mem [TASK_SLOTS];

  logic [TASK_SLOTS-1:0] cnt_vld_q, cnt_vld_d;
  logic [TASK_SLOTS-1:0] pri_vld_q, pri_vld_d;
  logic [TASK_SLOTS-1:0] present_q, present_d;
  logic [TASK_SLOTS-1:0] ready_q, ready_d;

  logic [IDX_W-1:0] cur_q, cur_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [IDX_W-1:0] ev_idx_q;
  logic             ev_vld_q, ev_rech_q;
  logic             ev_cvld_q, ev_pvld_q;
  logic [CNT_W-1:0] cnt_rd_q;
  logic [PRI_W-1:0] pri_rd_q;

  logic             found_q, found_d;
  logic [IDX_W-1:0] best_idx_q, best_idx_d;
  logic [CNT_W-1:0] best_cnt_q, best_cnt_d;

  logic                  out_valid_q, out_valid_d;
  logic [TASK_IDX_W-1:0] out_next_q, out_next_d;
  logic                  out_switched_q, out_switched_d;
  logic                  out_idle_q, out_idle_d;
  logic                  out_rech_q, out_rech_d;

  logic             wr_in_range;
  logic [IDX_W-1:0] wr_addr;
  logic [CNT_W-1:0] cnt_val, rech_val;
  logic [PRI_W-1:0] pri_val;
  logic             ev_cand, ev_scan, ev_write;
  logic             cnt_we, pri_we;
  logic [IDX_W-1:0] cnt_wa;
  logic [CNT_W-1:0] cnt_wd;

  assign wr_in_range = int'(task_index_i) < TASK_SLOTS;
  assign wr_addr     = IDX_W'(task_index_i);

  assign cnt_val  = ev_cvld_q ? cnt_rd_q : '0;
  assign pri_val  = ev_pvld_q ? pri_rd_q : ((ev_idx_q == '0) ? PRI_W'(1) : '0);
  assign rech_val = CNT_W'(cnt_val >> 1) + CNT_W'(pri_val);
  assign ev_cand  = present_q[ev_idx_q] && ready_q[ev_idx_q];
  assign ev_scan  = ev_vld_q && !ev_rech_q && ev_cand;
  assign ev_write = ev_vld_q && ev_rech_q && present_q[ev_idx_q];

  assign pri_we = cmd_i.wr_entry && wr_in_range;

  // One write port on the counter store, shared by entry loads and recharge
  always_comb begin
    cnt_we = 1'b0;
    cnt_wa = ev_idx_q;
    cnt_wd = rech_val;
    if (cmd_i.wr_entry && wr_in_range) begin
      cnt_we = 1'b1;
      cnt_wa = wr_addr;
      cnt_wd = slice_count_i;
    end else if (ev_write) begin
      cnt_we = 1'b1;
    end
  end

  always_comb begin
    cnt_vld_d = cnt_vld_q;
    pri_vld_d = pri_vld_q;
    present_d = present_q;
    ready_d   = ready_q;
    if (cnt_we) begin
      cnt_vld_d[cnt_wa] = 1'b1;
    end
    if (pri_we) begin
      pri_vld_d[wr_addr] = 1'b1;
      present_d[wr_addr] = present_i;
      ready_d[wr_addr]   = ready_req_i;
    end
    if (cmd_i.clear_cur) begin
      cnt_vld_d[cur_q] = 1'b0;
    end
  end

  always_comb begin
    idx_d      = idx_q;
    found_d    = found_q || ev_scan;
    best_idx_d = best_idx_q;
    best_cnt_d = best_cnt_q;
    if (ev_scan && (!found_q || cnt_val > best_cnt_q)) begin
      best_idx_d = ev_idx_q;
      best_cnt_d = cnt_val;
    end
    if (cmd_i.pass_run) begin
      idx_d = idx_q + IDX_W'(1);
    end
    if (cmd_i.pass_start) begin
      idx_d      = '0;
      found_d    = 1'b0;
      best_idx_d = '0;
      best_cnt_d = '0;
    end
  end

  always_comb begin
    out_valid_d    = out_valid_q && !out_ready_i;
    out_next_d     = out_next_q;
    out_switched_d = out_switched_q;
    out_idle_d     = out_idle_q;
    out_rech_d     = out_rech_q;
    cur_d          = cur_q;
    if (cmd_i.out_load) begin
      out_valid_d    = 1'b1;
      out_next_d     = TASK_IDX_W'(cur_q);
      out_switched_d = 1'b0;
      out_idle_d     = 1'b0;
      out_rech_d     = cmd_i.res_rech;
      unique case (cmd_i.res_kind)
        RES_WRITE: begin
          out_rech_d = 1'b0;
        end
        RES_IDLE: begin
          out_idle_d = 1'b1;
        end
        RES_SEL: begin
          out_next_d     = TASK_IDX_W'(best_idx_q);
          out_switched_d = (best_idx_q != cur_q);
          cur_d          = best_idx_q;
        end
        default: begin
          out_idle_d = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_vld_q   <= '0;
      pri_vld_q   <= '0;
      present_q   <= TASK_SLOTS'(1);
      ready_q     <= TASK_SLOTS'(1);
      cur_q       <= '0;
      idx_q       <= '0;
      ev_vld_q    <= 1'b0;
      ev_rech_q   <= 1'b0;
      ev_idx_q    <= '0;
      ev_cvld_q   <= 1'b0;
      ev_pvld_q   <= 1'b0;
      found_q     <= 1'b0;
      best_idx_q  <= '0;
      best_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_vld_q   <= cnt_vld_d;
      pri_vld_q   <= pri_vld_d;
      present_q   <= present_d;
      ready_q     <= ready_d;
      cur_q       <= cur_d;
      idx_q       <= idx_d;
      ev_vld_q    <= cmd_i.pass_run;
      ev_rech_q   <= cmd_i.rech_mode;
      ev_idx_q    <= idx_q;
      ev_cvld_q   <= cnt_vld_q[idx_q];
      ev_pvld_q   <= pri_vld_q[idx_q];
      found_q     <= found_d;
      best_idx_q  <= best_idx_d;
      best_cnt_q  <= best_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_next_q     <= out_next_d;
    out_switched_q <= out_switched_d;
    out_idle_q     <= out_idle_d;
    out_rech_q     <= out_rech_d;
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    if (pri_we) begin
      pri_mem[wr_addr] <= weight_i;
    end
    if (cmd_i.pass_run) begin
      cnt_rd_q <= cnt_mem[idx_q];
      pri_rd_q <= pri_mem[idx_q];
    end
  end

  assign status_o.issue_last = (idx_q == IDX_W'(TASK_SLOTS - 1));
  assign status_o.found      = found_q;
  assign status_o.best_zero  = (best_cnt_q == '0);
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign next_task_o = out_next_q;
  assign switched_o  = out_switched_q;
  assign idle_o      = out_idle_q;
  assign recharged_o = out_rech_q;

  a_sel_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load && cmd_i.res_kind == RES_SEL |-> found_q && best_cnt_q != '0)
    else $error("selected a task without a nonzero counter");

  a_write_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_entry |-> !ev_vld_q)
    else $error("entry load collided with a table pass");

  a_idle_no_switch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_idle_q |-> !out_switched_q)
    else $error("idle result reports a task switch");

endmodule

`default_nettype wire

>>> hdl/max_counter_task_scheduler.sv
// Counter-based task scheduler.
// Request channel (req_i): kind 0 loads one table entry (present, ready,
// counter, priority) at task_index; indexes beyond the table are ignored.
// kind 1 asks for a scheduling decision: the current task's counter is
// zeroed, then the present, ready task with the largest counter wins,
// lowest index on ties; none gives idle. If all their counters are zero,
// present entries are recharged to counter/2 + priority and the table is
// scanned again, and idle is reported if they are still zero.
// Result channel (rsp_o): one transaction per request with next_task,
// switched, idle and recharged. One request is handled at a time.
// A load goes via the result state to the output register; a decision
// runs a scan pass, a wait state and the decision step; a needed recharge
// adds a recharge pass and its wait, then scan, wait and decision again.
// The next request is taken in the cycle after the result is loaded. Each
// pass reads one entry per cycle from the counter store's single read port.
// Reset leaves entry 0 present and ready with priority one, every other
// entry empty, all counters zero and task 0 current; no clearing pass.
// A stalled receiver holds the result in the output register; the block
// still takes one more request and works on it, then holds that request's
// result until the register has been freed.
`timescale 1ns / 1ps
`default_nettype none

module max_counter_task_scheduler #(
  parameter int TASK_SLOTS = 64
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  mcts_in_if.sink     req_i,
  mcts_out_if.source  rsp_o
);
  import mcts_pkg::*;

  mcts_cmd_t    cmd;
  mcts_status_t status;

  mcts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_kind_i  (req_i.kind),
    .in_ready_o (req_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mcts_datapath #(
    .TASK_SLOTS (TASK_SLOTS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .task_index_i  (req_i.task_index),
    .present_i     (req_i.present),
    .ready_req_i   (req_i.ready_req),
    .slice_count_i (req_i.slice_count),
    .weight_i      (req_i.weight),
    .out_valid_o   (rsp_o.valid),
    .out_ready_i   (rsp_o.ready),
    .next_task_o   (rsp_o.next_task),
    .switched_o    (rsp_o.switched),
    .idle_o        (rsp_o.idle),
    .recharged_o   (rsp_o.recharged)
  );

endmodule

`default_nettype wire

>>> sim/max_counter_task_scheduler_test.sv
`timescale 1ns / 1ps

module max_counter_task_scheduler_test;
  import mcts_pkg::*;

  localparam int SLOTS          = 64;
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES    = 3 * SLOTS + 20;

  typedef struct packed {
    logic                  kind;
    logic [TASK_IDX_W-1:0] task_index;
    logic                  present;
    logic                  ready_req;
    logic [CNT_W-1:0]      slice_count;
    logic [PRI_W-1:0]      weight;
  } sched_req_t;

  typedef struct packed {
    logic [TASK_IDX_W-1:0] next_task;
    logic                  switched;
    logic                  idle;
    logic                  recharged;
  } sched_result_t;

  logic clk;
  logic rst_n;

  mcts_in_if  req_if ();
  mcts_out_if rsp_if ();

  max_counter_task_scheduler #(
    .TASK_SLOTS(SLOTS)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Shadow copy of the task table
  logic                  slot_present [SLOTS];
  logic                  slot_ready   [SLOTS];
  logic [CNT_W-1:0]      slot_count   [SLOTS];
  logic [PRI_W-1:0]      slot_weight  [SLOTS];
  logic [TASK_IDX_W-1:0] running_task;

  sched_req_t    pending_reqs[$];
  sched_result_t expected_results[$];
  sched_req_t    taken_req;
  sched_req_t    offered_req;
  sched_result_t seen_result;
  sched_result_t want_result;

  int send_idle_pct;
  int stall_pct;
  int hold_requests;
  int holds_done;
  int stall_left;
  int quiet_cycles;
  int fail_count;

  function automatic void find_busiest(output bit found, output logic [TASK_IDX_W-1:0] idx,
                                       output logic [CNT_W-1:0] cnt);
    found = 1'b0;
    idx   = '0;
    cnt   = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_present[i] && slot_ready[i] && (!found || slot_count[i] > cnt)) begin
        cnt = slot_count[i];
        idx = i[TASK_IDX_W-1:0];
      end
      if (slot_present[i] && slot_ready[i]) found = 1'b1;
    end
  endfunction

  function automatic sched_result_t apply_request(sched_req_t r);
    sched_result_t         res;
    bit                    found;
    logic [TASK_IDX_W-1:0] best_idx;
    logic [CNT_W-1:0]      best_cnt;
    logic [TASK_IDX_W-1:0] prev;
    prev          = running_task;
    res.next_task = prev;
    res.switched  = 1'b0;
    res.idle      = 1'b0;
    res.recharged = 1'b0;
    if (r.kind == KIND_WRITE) begin
      slot_present[r.task_index] = r.present;
      slot_ready[r.task_index]   = r.ready_req;
      slot_count[r.task_index]   = r.slice_count;
      slot_weight[r.task_index]  = r.weight;
    end else begin
      slot_count[prev] = '0;
      find_busiest(found, best_idx, best_cnt);
      if (!found) begin
        res.idle = 1'b1;
      end else begin
        if (best_cnt == 0) begin
          res.recharged = 1'b1;
          for (int i = 0; i < SLOTS; i++) begin
            if (slot_present[i]) slot_count[i] = (slot_count[i] >> 1) + {1'b0, slot_weight[i]};
          end
          find_busiest(found, best_idx, best_cnt);
        end
        if (best_cnt == 0) begin
          res.idle = 1'b1;
        end else begin
          res.next_task = best_idx;
          res.switched  = (best_idx != prev);
          running_task  = best_idx;
        end
      end
    end
    return res;
  endfunction

  function automatic sched_req_t make_write(int idx, bit p, bit rdy, int cnt, int w);
    sched_req_t r;
    r.kind        = KIND_WRITE;
    r.task_index  = idx[TASK_IDX_W-1:0];
    r.present     = p;
    r.ready_req   = rdy;
    r.slice_count = cnt[CNT_W-1:0];
    r.weight      = w[PRI_W-1:0];
    return r;
  endfunction

  // Payload other than kind is don't-care on a decision; randomize it anyway
  function automatic sched_req_t make_sched();
    sched_req_t r;
    r      = make_write($urandom_range(0, 63), 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)), $urandom_range(0, 511),
                        $urandom_range(0, 255));
    r.kind = KIND_SCHED;
    return r;
  endfunction

  function automatic sched_req_t random_write(bit vacate);
    int idx;
    int cnt;
    int w;
    idx = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 7) : $urandom_range(0, 63);
    case ($urandom_range(0, 3))
      0:       cnt = 0;
      1:       cnt = $urandom_range(0, 3);
      default: cnt = $urandom_range(0, 511);
    endcase
    case ($urandom_range(0, 3))
      0:       w = 0;
      1:       w = $urandom_range(0, 3);
      default: w = $urandom_range(0, 255);
    endcase
    return make_write(idx, vacate ? 1'b0 : ($urandom_range(0, 9) < 8),
                      $urandom_range(0, 9) < 7, cnt, w);
  endfunction

  // Episodes of a few table loads followed by a burst of decisions
  task automatic queue_random(int n);
    int queued;
    int n_wr;
    int n_sc;
    bit vacate;
    queued = 0;
    while (queued < n) begin
      vacate = ($urandom_range(0, 9) == 0);
      n_wr   = $urandom_range(0, 5);
      n_sc   = $urandom_range(1, 4);
      repeat (n_wr) pending_reqs.push_back(random_write(vacate));
      repeat (n_sc) pending_reqs.push_back(make_sched());
      queued += n_wr + n_sc;
    end
  endtask

  task automatic run_phase(int send_pct, int recv_pct, int n_items, bit long_hold);
    @(negedge clk);
    send_idle_pct = send_pct;
    stall_pct     = recv_pct;
    if (long_hold) hold_requests = hold_requests + 1;
    queue_random(n_items);
    while (pending_reqs.size() != 0 || req_if.valid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  // Request driver
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        taken_req.kind        = req_if.kind;
        taken_req.task_index  = req_if.task_index;
        taken_req.present     = req_if.present;
        taken_req.ready_req   = req_if.ready_req;
        taken_req.slice_count = req_if.slice_count;
        taken_req.weight      = req_if.weight;
        expected_results.push_back(apply_request(taken_req));
      end
      if (!req_if.valid || req_if.ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          offered_req           = pending_reqs.pop_front();
          req_if.valid         <= 1'b1;
          req_if.kind          <= offered_req.kind;
          req_if.task_index    <= offered_req.task_index;
          req_if.present       <= offered_req.present;
          req_if.ready_req     <= offered_req.ready_req;
          req_if.slice_count   <= offered_req.slice_count;
          req_if.weight        <= offered_req.weight;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver back-pressure
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      rsp_if.ready <= 1'b0;
      stall_left   <= 0;
      holds_done   <= 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        seen_result.next_task = rsp_if.next_task;
        seen_result.switched  = rsp_if.switched;
        seen_result.idle      = rsp_if.idle;
        seen_result.recharged = rsp_if.recharged;
        if (expected_results.size() == 0) begin
          $error("unexpected result transaction: next_task %0d", seen_result.next_task);
          fail_count = fail_count + 1;
        end else begin
          want_result = expected_results.pop_front();
          if (seen_result.next_task !== want_result.next_task) begin
            $error("next_task: expected %0d, got %0d", want_result.next_task,
                   seen_result.next_task);
            fail_count = fail_count + 1;
          end
          if (seen_result.switched !== want_result.switched) begin
            $error("switched: expected %0b, got %0b", want_result.switched,
                   seen_result.switched);
            fail_count = fail_count + 1;
          end
          if (seen_result.idle !== want_result.idle) begin
            $error("idle: expected %0b, got %0b", want_result.idle, seen_result.idle);
            fail_count = fail_count + 1;
          end
          if (seen_result.recharged !== want_result.recharged) begin
            $error("recharged: expected %0b, got %0b", want_result.recharged,
                   seen_result.recharged);
            fail_count = fail_count + 1;
          end
        end
      end
      if (holds_done != hold_requests) begin
        holds_done   <= holds_done + 1;
        stall_left   <= LONG_HOLD;
        rsp_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left   <= stall_left - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("max_counter_task_scheduler_test: done, errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    rst_n              = 1'b0;
    req_if.valid       = 1'b0;
    req_if.kind        = KIND_WRITE;
    req_if.task_index  = '0;
    req_if.present     = 1'b0;
    req_if.ready_req   = 1'b0;
    req_if.slice_count = '0;
    req_if.weight      = '0;
    rsp_if.ready       = 1'b0;
    send_idle_pct      = 0;
    stall_pct          = 0;
    hold_requests      = 0;
    quiet_cycles       = 0;
    fail_count         = 0;
    for (int i = 0; i < SLOTS; i++) begin
      slot_present[i] = (i == 0);
      slot_ready[i]   = (i == 0);
      slot_count[i]   = '0;
      slot_weight[i]  = (i == 0) ? 8'd1 : 8'd0;
    end
    running_task = '0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Decision straight out of reset forces a recharge of task 0
    pending_reqs.push_back(make_sched());
    pending_reqs.push_back(make_write(63, 1, 1, 511, 255));
    pending_reqs.push_back(make_write(5, 1, 1, 511, 0));
    // Tie on the largest counter goes to the lower index
    pending_reqs.push_back(make_sched());
    pending_reqs.push_back(make_sched());
    // Ready but not present must never be chosen
    pending_reqs.push_back(make_write(10, 0, 1, 300, 200));
    pending_reqs.push_back(make_sched());
    // Drop every ready task: idle without recharge
    pending_reqs.push_back(make_write(0, 0, 0, 0, 0));
    pending_reqs.push_back(make_write(5, 1, 0, 0, 0));
    pending_reqs.push_back(make_write(63, 1, 0, 511, 255));
    pending_reqs.push_back(make_sched());
    // Only zero-priority ready tasks: recharge, then idle
    pending_reqs.push_back(make_write(7, 1, 1, 0, 0));
    pending_reqs.push_back(make_write(20, 1, 0, 511, 255));
    pending_reqs.push_back(make_sched());
    pending_reqs.push_back(make_write(3, 1, 1, 0, 255));
    pending_reqs.push_back(make_write(7, 1, 1, 0, 255));
    pending_reqs.push_back(make_sched());
    pending_reqs.push_back(make_sched());
    pending_reqs.push_back(make_write(20, 1, 1, 0, 1));
    pending_reqs.push_back(make_sched());
    pending_reqs.push_back(make_sched());
    run_phase(0, 0, 0, 1'b0);

    run_phase(0, 0, 160, 1'b0);
    run_phase(71, 0, 160, 1'b0);
    run_phase(0, 71, 160, 1'b0);
    run_phase(36, 36, 160, 1'b0);
    // Receiver holds off while requests keep coming, so the input backs up
    run_phase(0, 0, 160, 1'b1);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("results missing at end of run: %0d", expected_results.size());
      fail_count = fail_count + 1;
    end
    if (fail_count == 0) begin
      $display("max_counter_task_scheduler_test: done, clean");
    end else begin
      $display("max_counter_task_scheduler_test: done, errors");
    end
    $finish;
  end

endmodule
